// ===== sv/baud_prescaler_search_defines.svh =====
// assertion macros used by the port-level checker
`ifndef BAUD_PRESCALER_SEARCH_DEFINES_SVH
`define BAUD_PRESCALER_SEARCH_DEFINES_SVH

// same-cycle implication under reset
`define BPS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("baud prescaler search check failed");

// next-cycle implication under reset
`define BPS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("baud prescaler search check failed");

`endif

// ===== sv/bps_pkg.sv =====
// constants, tables, step codes and microprogram rom of the baud prescaler search
package bps_pkg;

	// field widths
	localparam int OSC_W    = 26;
	localparam int LIMIT_W  = 14;
	localparam int TGT_W    = 21;
	localparam int RATE_W   = 17;
	localparam int TENTHS_W = 10;
	localparam int IDX_W    = 3;

	// shared divider: dividend of diff*10000, divisor up to one table rate
	localparam int DVD_W     = TGT_W + LIMIT_W;
	localparam int DVS_W     = RATE_W;
	localparam int DIV_CNT_W = 6;
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DVD_W - 1);

	// rounding divide by ten as a reciprocal multiply, exact below 2^18
	localparam int RND_W    = 32;
	localparam int RECIP_SH = 19;
	localparam int RND_Q_W  = RND_W - RECIP_SH;
	localparam logic [15:0] RECIP_10 = 16'd52429;

	localparam logic [LIMIT_W-1:0]  LIMIT_RESET = 14'd300;
	localparam logic [LIMIT_W-1:0]  ERR_SCALE   = 14'd10000;
	localparam logic [TENTHS_W-1:0] TENTHS_MAX  = 10'd1000;
	localparam logic [IDX_W-1:0]    IDX_LAST    = 3'd7;

	// datapath operations
	localparam logic [3:0] OP_NOP     = 4'd0;
	localparam logic [3:0] OP_LOAD    = 4'd1;
	localparam logic [3:0] OP_DIV_T   = 4'd2;
	localparam logic [3:0] OP_SET_T   = 4'd3;
	localparam logic [3:0] OP_DIFF    = 4'd4;
	localparam logic [3:0] OP_MUL     = 4'd5;
	localparam logic [3:0] OP_DIV_E   = 4'd6;
	localparam logic [3:0] OP_SET_E   = 4'd7;
	localparam logic [3:0] OP_INC_R   = 4'd8;
	localparam logic [3:0] OP_INC_P   = 4'd9;
	localparam logic [3:0] OP_WR_MISS = 4'd10;
	localparam logic [3:0] OP_DIV_10  = 4'd11;
	localparam logic [3:0] OP_WR_HIT  = 4'd12;

	// jump conditions
	localparam logic [2:0] C_NEVER    = 3'd0;
	localparam logic [2:0] C_ALWAYS   = 3'd1;
	localparam logic [2:0] C_NO_IN    = 3'd2;
	localparam logic [2:0] C_DIV_BUSY = 3'd3;
	localparam logic [2:0] C_BELOW    = 3'd4;
	localparam logic [2:0] C_R_MORE   = 3'd5;
	localparam logic [2:0] C_P_MORE   = 3'd6;
	localparam logic [2:0] C_OUT_FULL = 3'd7;

	// program steps
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] S_IDLE    = 4'd0;
	localparam logic [STEP_W-1:0] S_DIV_T   = 4'd1;
	localparam logic [STEP_W-1:0] S_SET_T   = 4'd2;
	localparam logic [STEP_W-1:0] S_DIFF    = 4'd3;
	localparam logic [STEP_W-1:0] S_MUL     = 4'd4;
	localparam logic [STEP_W-1:0] S_DIV_E   = 4'd5;
	localparam logic [STEP_W-1:0] S_CMP     = 4'd6;
	localparam logic [STEP_W-1:0] S_NEXT_R  = 4'd7;
	localparam logic [STEP_W-1:0] S_NEXT_P  = 4'd8;
	localparam logic [STEP_W-1:0] S_MISS    = 4'd9;
	localparam logic [STEP_W-1:0] S_MISS_GO = 4'd10;
	localparam logic [STEP_W-1:0] S_DIV_10  = 4'd11;
	localparam logic [STEP_W-1:0] S_HIT     = 4'd12;
	localparam logic [STEP_W-1:0] S_HIT_GO  = 4'd13;

	typedef struct packed {
		logic [3:0]        op;
		logic [2:0]        cond;
		logic [STEP_W-1:0] target;
	} ctrl_word_t;

	// microprogram: jump to target when cond holds, else fall through
	function automatic ctrl_word_t ucode_rom(input logic [STEP_W-1:0] step);
		ctrl_word_t cw;
		case (step)
			S_IDLE:    cw = '{OP_LOAD,    C_NO_IN,    S_IDLE};
			S_DIV_T:   cw = '{OP_DIV_T,   C_DIV_BUSY, S_DIV_T};
			S_SET_T:   cw = '{OP_SET_T,   C_NEVER,    S_IDLE};
			S_DIFF:    cw = '{OP_DIFF,    C_NEVER,    S_IDLE};
			S_MUL:     cw = '{OP_MUL,     C_NEVER,    S_IDLE};
			S_DIV_E:   cw = '{OP_DIV_E,   C_DIV_BUSY, S_DIV_E};
			S_CMP:     cw = '{OP_SET_E,   C_BELOW,    S_DIV_10};
			S_NEXT_R:  cw = '{OP_INC_R,   C_R_MORE,   S_DIFF};
			S_NEXT_P:  cw = '{OP_INC_P,   C_P_MORE,   S_DIV_T};
			S_MISS:    cw = '{OP_WR_MISS, C_OUT_FULL, S_MISS};
			S_MISS_GO: cw = '{OP_NOP,     C_ALWAYS,   S_IDLE};
			S_DIV_10:  cw = '{OP_DIV_10,  C_NEVER,    S_IDLE};
			S_HIT:     cw = '{OP_WR_HIT,  C_OUT_FULL, S_HIT};
			S_HIT_GO:  cw = '{OP_NOP,     C_ALWAYS,   S_IDLE};
			default:   cw = '{OP_NOP,     C_ALWAYS,   S_IDLE};
		endcase
		return cw;
	endfunction

	// prescaler table
	function automatic logic [5:0] presc_tab(input logic [IDX_W-1:0] i);
		logic [5:0] v;
		case (i)
			3'd0:    v = 6'd1;
			3'd1:    v = 6'd2;
			3'd2:    v = 6'd4;
			3'd3:    v = 6'd9;
			3'd4:    v = 6'd7;
			3'd5:    v = 6'd13;
			3'd6:    v = 6'd26;
			3'd7:    v = 6'd52;
			default: v = 6'd1;
		endcase
		return v;
	endfunction

	// standard baud table
	function automatic logic [RATE_W-1:0] rate_tab(input logic [IDX_W-1:0] i);
		logic [RATE_W-1:0] v;
		case (i)
			3'd0:    v = 17'd115200;
			3'd1:    v = 17'd57600;
			3'd2:    v = 17'd38400;
			3'd3:    v = 17'd19200;
			3'd4:    v = 17'd9600;
			3'd5:    v = 17'd4800;
			3'd6:    v = 17'd2400;
			3'd7:    v = 17'd1200;
			default: v = 17'd1200;
		endcase
		return v;
	endfunction

endpackage

// ===== sv/baud_prescaler_search.sv =====
// Baud prescaler search: 8 prescalers x 8 standard rates, first pair under the error limit.
// Per prescaler visited the target rate is divided out, per pair tried the error, both on
// the shared 35-step restoring divider; a hit adds a reciprocal rounding step before its write.
// One item at a time; the next item is taken once the result sits in the output register.
// Reset (arst_n low, asynchronous) returns to the idle step, empties the output, limit = 300.
module baud_prescaler_search (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bps_pkg::LIMIT_W-1:0]         cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [bps_pkg::OSC_W-1:0]           osc_hz,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                found,
	output logic [bps_pkg::IDX_W-1:0]           baud_index,
	output logic [bps_pkg::IDX_W-1:0]           prescaler_index,
	output logic [bps_pkg::RATE_W-1:0]          local_baud,
	output logic [bps_pkg::TGT_W-1:0]           target_baud,
	output logic [bps_pkg::TENTHS_W-1:0]        error_tenths
);

	// sequencer state
	logic [bps_pkg::STEP_W-1:0]    pc_q, pc_d;
	bps_pkg::ctrl_word_t           cw;
	logic                          cond_hit;

	// control and datapath registers
	logic [bps_pkg::LIMIT_W-1:0]   limit_q;
	logic [bps_pkg::TGT_W-1:0]     osc_q;
	logic [bps_pkg::IDX_W-1:0]     p_q, r_q;
	logic [bps_pkg::TGT_W-1:0]     target_q;
	logic [bps_pkg::TGT_W-1:0]     diff_q;
	logic [bps_pkg::DVD_W-1:0]     prod_q;
	logic [bps_pkg::LIMIT_W-1:0]   err_q;
	logic [bps_pkg::TENTHS_W-1:0]  tenths_q;

	// shared divider
	logic                          div_busy_q;
	logic [bps_pkg::DIV_CNT_W-1:0] div_cnt_q;
	logic [bps_pkg::DVD_W-1:0]     quo_q;
	logic [bps_pkg::DVS_W-1:0]     rem_q, den_q;
	logic [bps_pkg::DVS_W:0]       trial;
	logic                          trial_ge;
	logic                          div_op, div_done;
	logic [bps_pkg::DVD_W-1:0]     dvd_sel;
	logic [bps_pkg::DVS_W-1:0]     dvs_sel;

	// rounding to tenths
	logic [bps_pkg::LIMIT_W:0]     err_rnd;
	logic [bps_pkg::RND_W-1:0]     rnd_prod;
	logic [bps_pkg::RND_Q_W-1:0]   rnd_quo;

	// output register
	logic                          out_valid_q;
	logic                          out_free;
	logic                          in_accept;
	logic                          wr_en;
	logic [bps_pkg::RATE_W-1:0]    rate_cur;
	logic [bps_pkg::TGT_W-1:0]     rate_ext;
	logic [bps_pkg::TENTHS_W-1:0]  tenths_sat;

	assign cw        = bps_pkg::ucode_rom(pc_q);
	assign cfg_ready = 1'b1;
	assign in_stall  = (pc_q != bps_pkg::S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign rate_cur  = bps_pkg::rate_tab(r_q);
	assign rate_ext  = bps_pkg::TGT_W'(rate_cur);

	// divider operand selection
	assign div_op = (cw.op == bps_pkg::OP_DIV_T) || (cw.op == bps_pkg::OP_DIV_E);
	always_comb begin
		case (cw.op)
			bps_pkg::OP_DIV_T: begin
				dvd_sel = bps_pkg::DVD_W'(osc_q);
				dvs_sel = bps_pkg::DVS_W'(bps_pkg::presc_tab(p_q));
			end
			bps_pkg::OP_DIV_E: begin
				dvd_sel = prod_q;
				dvs_sel = rate_cur;
			end
			default: begin
				dvd_sel = '0;
				dvs_sel = bps_pkg::DVS_W'(1);
			end
		endcase
	end

	// one restoring step
	assign trial    = {rem_q, quo_q[bps_pkg::DVD_W-1]};
	assign trial_ge = (trial >= {1'b0, den_q});
	assign div_done = div_busy_q && (div_cnt_q == bps_pkg::DIV_LAST);

	// jump condition
	always_comb begin
		case (cw.cond)
			bps_pkg::C_NEVER:    cond_hit = 1'b0;
			bps_pkg::C_ALWAYS:   cond_hit = 1'b1;
			bps_pkg::C_NO_IN:    cond_hit = !in_accept;
			bps_pkg::C_DIV_BUSY: cond_hit = !div_done;
			bps_pkg::C_BELOW:    cond_hit = (quo_q < bps_pkg::DVD_W'(limit_q));
			bps_pkg::C_R_MORE:   cond_hit = (r_q != bps_pkg::IDX_LAST);
			bps_pkg::C_P_MORE:   cond_hit = (p_q != bps_pkg::IDX_LAST);
			bps_pkg::C_OUT_FULL: cond_hit = !out_free;
			default:             cond_hit = 1'b0;
		endcase
	end

	assign pc_d  = cond_hit ? cw.target : pc_q + bps_pkg::STEP_W'(1);
	assign wr_en = out_free &&
			((cw.op == bps_pkg::OP_WR_HIT) || (cw.op == bps_pkg::OP_WR_MISS));

	// (err + 5) / 10 by reciprocal multiply, saturated
	assign err_rnd    = (bps_pkg::LIMIT_W+1)'(err_q) + (bps_pkg::LIMIT_W+1)'(5);
	assign rnd_prod   = bps_pkg::RND_W'(err_rnd) * bps_pkg::RND_W'(bps_pkg::RECIP_10);
	assign rnd_quo    = rnd_prod[bps_pkg::RND_W-1:bps_pkg::RECIP_SH];
	assign tenths_sat = (rnd_quo > bps_pkg::RND_Q_W'(bps_pkg::TENTHS_MAX)) ?
			bps_pkg::TENTHS_MAX : rnd_quo[bps_pkg::TENTHS_W-1:0];

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= bps_pkg::S_IDLE;
			limit_q     <= bps_pkg::LIMIT_RESET;
			div_busy_q  <= 1'b0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			pc_q <= pc_d;
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
			if (div_op && !div_busy_q) begin
				div_busy_q <= 1'b1;
				div_cnt_q  <= '0;
			end else if (div_busy_q) begin
				div_cnt_q <= div_cnt_q + bps_pkg::DIV_CNT_W'(1);
				if (div_done) begin
					div_busy_q <= 1'b0;
				end
			end
			if (wr_en) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// divider datapath
	always_ff @(posedge clk) begin
		if (div_op && !div_busy_q) begin
			quo_q <= dvd_sel;
			rem_q <= '0;
			den_q <= dvs_sel;
		end else if (div_busy_q) begin
			quo_q <= {quo_q[bps_pkg::DVD_W-2:0], trial_ge};
			rem_q <= trial_ge ? bps_pkg::DVS_W'(trial - {1'b0, den_q}) :
					trial[bps_pkg::DVS_W-1:0];
		end
	end

	// search datapath driven by the control word
	always_ff @(posedge clk) begin
		case (cw.op)
			bps_pkg::OP_LOAD: begin
				if (in_accept) begin
					osc_q <= osc_hz[bps_pkg::OSC_W-1:bps_pkg::OSC_W-bps_pkg::TGT_W];
					p_q   <= '0;
				end
			end
			bps_pkg::OP_SET_T: begin
				target_q <= quo_q[bps_pkg::TGT_W-1:0];
				r_q      <= '0;
			end
			bps_pkg::OP_DIFF: begin
				diff_q <= (target_q >= rate_ext) ? target_q - rate_ext : rate_ext - target_q;
			end
			bps_pkg::OP_MUL: begin
				prod_q <= bps_pkg::DVD_W'(diff_q) * bps_pkg::DVD_W'(bps_pkg::ERR_SCALE);
			end
			bps_pkg::OP_SET_E: begin
				err_q <= quo_q[bps_pkg::LIMIT_W-1:0];
			end
			bps_pkg::OP_DIV_10: begin
				tenths_q <= tenths_sat;
			end
			bps_pkg::OP_INC_R: begin
				r_q <= r_q + bps_pkg::IDX_W'(1);
			end
			bps_pkg::OP_INC_P: begin
				p_q <= p_q + bps_pkg::IDX_W'(1);
			end
			default: begin
			end
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (wr_en) begin
			if (cw.op == bps_pkg::OP_WR_HIT) begin
				found           <= 1'b1;
				baud_index      <= r_q;
				prescaler_index <= p_q;
				local_baud      <= rate_cur;
				target_baud     <= target_q;
				error_tenths    <= tenths_q;
			end else begin
				found           <= 1'b0;
				baud_index      <= '0;
				prescaler_index <= '0;
				local_baud      <= '0;
				target_baud     <= '0;
				error_tenths    <= '0;
			end
		end
	end

endmodule

// ===== sv/bps_check.sv =====
// port-level checker for the baud prescaler search, bound to the top level
`include "baud_prescaler_search_defines.svh"

module bps_check (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic                                found,
	input logic [bps_pkg::IDX_W-1:0]           baud_index,
	input logic [bps_pkg::IDX_W-1:0]           prescaler_index,
	input logic [bps_pkg::RATE_W-1:0]          local_baud,
	input logic [bps_pkg::TGT_W-1:0]           target_baud,
	input logic [bps_pkg::TENTHS_W-1:0]        error_tenths
);

	// a stalled result beat stays offered
	`BPS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

	// after taking an item the search is busy
	`BPS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

	// a miss reports all-zero fields
	`BPS_ASSERT_NOW(a_miss_zero, out_valid && !found,
		baud_index == '0 && prescaler_index == '0 && local_baud == '0 &&
		target_baud == '0 && error_tenths == '0)

	// a hit carries a table rate and a saturated error
	`BPS_ASSERT_NOW(a_hit_sane, out_valid && found,
		local_baud != '0 && error_tenths <= bps_pkg::TENTHS_MAX)

endmodule

bind baud_prescaler_search bps_check u_bps_check (.*);

// ===== dv/tb_baud_prescaler_search.sv =====
// self-checking testbench for the baud prescaler search block
`timescale 1ns / 1ps

// predicts the chosen baud pair for each osc beat and checks result beats in order
class baud_search_board;
	typedef struct packed {
		logic                             found;
		logic [bps_pkg::IDX_W-1:0]        baud_index;
		logic [bps_pkg::IDX_W-1:0]        prescaler_index;
		logic [bps_pkg::RATE_W-1:0]       local_baud;
		logic [bps_pkg::TGT_W-1:0]        target_baud;
		logic [bps_pkg::TENTHS_W-1:0]     error_tenths;
	} baud_pick_t;

	int unsigned             rate_hz [8];
	int unsigned             presc_div [8];
	logic [bps_pkg::LIMIT_W-1:0] limit;
	baud_pick_t              pending_picks [$];
	int                      mismatches;
	int                      results_seen;

	function new();
		rate_hz = '{115200, 57600, 38400, 19200, 9600, 4800, 2400, 1200};
		presc_div = '{1, 2, 4, 9, 7, 13, 26, 52};
		limit = bps_pkg::LIMIT_RESET;
		mismatches = 0;
		results_seen = 0;
	endfunction

	// first prescaler/rate pair whose error is strictly under the limit
	function baud_pick_t pick_baud(input logic [bps_pkg::OSC_W-1:0] osc);
		baud_pick_t pick;
		longint unsigned tgt, dev, err, tenths;
		pick = '0;
		for (int p = 0; p < 8; p++) begin
			tgt = longint'(osc) / (32 * presc_div[p]);
			for (int r = 0; r < 8; r++) begin
				dev = (tgt >= rate_hz[r]) ? tgt - rate_hz[r] : rate_hz[r] - tgt;
				err = dev * 10000 / rate_hz[r];
				if (err < limit) begin
					tenths = (err + 5) / 10;
					if (tenths > 1000)
						tenths = 1000;
					pick.found = 1'b1;
					pick.baud_index = bps_pkg::IDX_W'(r);
					pick.prescaler_index = bps_pkg::IDX_W'(p);
					pick.local_baud = bps_pkg::RATE_W'(rate_hz[r]);
					pick.target_baud = bps_pkg::TGT_W'(tgt);
					pick.error_tenths = bps_pkg::TENTHS_W'(tenths);
					return pick;
				end
			end
		end
		return pick;
	endfunction

	function void note_osc(input logic [bps_pkg::OSC_W-1:0] osc);
		pending_picks.push_back(pick_baud(osc));
	endfunction

	function void flag(input string field, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result beat %0d: %s expected %0d, got %0d",
					results_seen, field, want, got);
		end
	endfunction

	function void check_pick(input baud_pick_t got);
		baud_pick_t want;
		results_seen++;
		if (pending_picks.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result beat %0d arrived with no osc beat outstanding",
					results_seen);
			return;
		end
		want = pending_picks.pop_front();
		flag("found", want.found, got.found);
		flag("baud_index", want.baud_index, got.baud_index);
		flag("prescaler_index", want.prescaler_index, got.prescaler_index);
		flag("local_baud", want.local_baud, got.local_baud);
		flag("target_baud", want.target_baud, got.target_baud);
		flag("error_tenths", want.error_tenths, got.error_tenths);
	endfunction
endclass

module tb_baud_prescaler_search;

	localparam longint unsigned OSC_MAX = (64'd1 << bps_pkg::OSC_W) - 1;
	localparam int STALL_LIMIT = 40000;
	localparam int HOLD_OFF = 6000;
	localparam int DRAIN_WAIT = 3000;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [bps_pkg::LIMIT_W-1:0]   cfg_data;
	logic                          in_valid;
	logic                          in_stall;
	logic [bps_pkg::OSC_W-1:0]     osc_hz;
	logic                          out_valid;
	logic                          out_stall;
	logic                          found;
	logic [bps_pkg::IDX_W-1:0]     baud_index;
	logic [bps_pkg::IDX_W-1:0]     prescaler_index;
	logic [bps_pkg::RATE_W-1:0]    local_baud;
	logic [bps_pkg::TGT_W-1:0]     target_baud;
	logic [bps_pkg::TENTHS_W-1:0]  error_tenths;

	baud_search_board board = new();
	int send_idle_pct;
	int recv_idle_pct;
	int hold_cycles;
	int quiet_cycles;

	baud_prescaler_search dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.osc_hz(osc_hz),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.found(found),
		.baud_index(baud_index),
		.prescaler_index(prescaler_index),
		.local_baud(local_baud),
		.target_baud(target_baud),
		.error_tenths(error_tenths)
	);

	always #6 clk = ~clk;

	// osc beat: optional gap, then hold the payload until accepted
	task automatic send_osc(input logic [bps_pkg::OSC_W-1:0] osc);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		osc_hz <= osc;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.note_osc(osc);
		@(negedge clk);
	endtask

	// limit write, only while the block is idle
	task automatic write_limit(input logic [bps_pkg::LIMIT_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		board.limit = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (board.pending_picks.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// mostly near 32 times a table rate times a prescaler, some wide and tiny values
	function automatic logic [bps_pkg::OSC_W-1:0] random_osc();
		int unsigned kind, p, r;
		longint unsigned base, delta;
		kind = $urandom_range(0, 9);
		if (kind <= 5) begin
			p = $urandom_range(0, 7);
			r = $urandom_range(0, 7);
			base = longint'(board.rate_hz[r]) * 32 * board.presc_div[p];
			while (base > OSC_MAX) begin
				p = $urandom_range(0, 3);
				base = longint'(board.rate_hz[r]) * 32 * board.presc_div[p];
			end
			delta = base * $urandom_range(0, 600) / 10000;
			if ($urandom_range(0, 1))
				base = base + delta;
			else
				base = base - delta;
			if (base > OSC_MAX)
				base = OSC_MAX;
			return base[bps_pkg::OSC_W-1:0];
		end else if (kind <= 7) begin
			return bps_pkg::OSC_W'($urandom());
		end
		return bps_pkg::OSC_W'($urandom_range(0, 70000));
	endfunction

	task automatic send_random(input int count);
		for (int i = 0; i < count; i++)
			send_osc(random_osc());
	endtask

	// receiver: random stalls, or a long hold-off when requested
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				hold_cycles--;
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_pick('{found, baud_index, prescaler_index, local_baud,
				target_baud, error_tenths});
	end

	// watchdog on cycles with no beat on any channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		osc_hz <= '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_cycles = 0;
		quiet_cycles = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset limit: exact hits, near hits, misses, field extremes
		send_osc('0);
		send_osc(bps_pkg::OSC_W'(OSC_MAX));
		send_osc(26'd3686400);
		send_osc(26'd1996800);
		send_osc(26'd2764800);
		send_osc(26'd7372800);
		send_osc(26'd1843200);
		send_osc(26'd37000);
		send_osc(26'd38000);
		send_osc(26'd3790000);
		wait_drained();

		// zero limit never finds a pair
		write_limit('0);
		send_osc(26'd3686400);
		send_osc('0);
		send_osc(26'd1996800);
		wait_drained();

		// widest limit: zero target and saturated rounded error
		write_limit({bps_pkg::LIMIT_W{1'b1}});
		send_osc('0);
		send_osc(26'd7424000);
		send_osc(bps_pkg::OSC_W'(OSC_MAX));
		wait_drained();

		// limit of exactly one hundred percent
		write_limit(bps_pkg::ERR_SCALE);
		send_osc('0);
		send_osc(26'd5000000);
		wait_drained();

		// limit of one: only pairs within one ten-thousandth of the rate
		write_limit(14'd1);
		send_osc(26'd3686400);
		send_osc(26'd3686432);
		send_osc(26'd15974400);
		wait_drained();

		// sender idles lightly, receiver mostly stalls
		write_limit(bps_pkg::LIMIT_RESET);
		send_idle_pct = 18;
		recv_idle_pct = 86;
		send_random(38);
		wait_drained();

		// receiver holds off while the sender keeps offering beats
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_cycles = HOLD_OFF;
		send_random(6);
		wait_drained();

		// sender mostly idles, receiver lightly stalls
		write_limit(bps_pkg::LIMIT_W'($urandom_range(1, 10000)));
		send_idle_pct = 86;
		recv_idle_pct = 18;
		send_random(38);
		wait_drained();

		// back to back
		write_limit(bps_pkg::LIMIT_W'($urandom_range(50, 600)));
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_random(38);
		wait_drained();

		repeat (DRAIN_WAIT) @(negedge clk);
		if (board.mismatches == 0 && board.pending_picks.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
